### hw/rtl/dcbpd_pkg.sv
// ----------------------------------------------------------------------------
// dcbpd_pkg: shared definitions for the dual-channel boxcar peak delay unit
// Holds default sizes, operation and register codes, and the command and
// status structs that pass between controller and datapath.
// ----------------------------------------------------------------------------
package dcbpd_pkg;

    // Default sizes handed to the top level parameters
    localparam int WINDOW_MAX_DEFAULT  = 256;
    localparam int SAMPLE_BITS_DEFAULT = 12;

    // Fixed widths of the block
    localparam int SUM_BITS       = 20;
    localparam int INDEX_BITS     = 20;
    localparam int WLEN_BITS      = 9;
    localparam int SEP_BITS       = 20;
    localparam int CFG_DATA_BITS  = 20;
    localparam int CFG_INDEX_BITS = 1;

    // Register values after reset
    localparam logic [WLEN_BITS-1:0] WLEN_RESET = WLEN_BITS'(201);
    localparam logic [SEP_BITS-1:0]  SEP_RESET  = SEP_BITS'(50000);

    // Input operation codes
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_REPORT = 1'b1
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_WINDOW_LENGTH  = 1'b0,
        CFG_MAX_SEPARATION = 1'b1
    } cfg_index_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // latch sample pair, read leaving entries
        logic accumulate;  // update sums, write history, start divide
        logic update;      // compare means against peaks
        logic report;      // load result, clear detector
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_done;    // quotients are ready
        logic out_free;    // output register can take a result now
    } dp_status_t;

endpackage

### hw/rtl/dcbpd_div.sv
// ----------------------------------------------------------------------------
// dcbpd_div: restoring unsigned divider
// Produces one quotient bit per cycle; done pulses for one cycle when the
// quotient is ready and it holds until the next start.
// ----------------------------------------------------------------------------
module dcbpd_div #(
    parameter int DIVIDEND_BITS = dcbpd_pkg::SUM_BITS,
    parameter int DIVISOR_BITS  = 9
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic [DIVIDEND_BITS-1:0] quotient,
    output logic                     done
);

    localparam int CNT_BITS = (DIVIDEND_BITS > 1) ? $clog2(DIVIDEND_BITS) : 1;
    localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIVIDEND_BITS - 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [CNT_BITS-1:0]      step_reg;
    logic [DIVISOR_BITS-1:0]  rem_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;

    logic [DIVISOR_BITS:0]    rem_shift;
    logic [DIVISOR_BITS+1:0]  trial;
    logic                     fits;
    logic [DIVISOR_BITS-1:0]  rem_next;
    logic [DIVIDEND_BITS-1:0] quo_next;

    // Shift in the next dividend bit and try a subtract
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        trial     = {1'b0, rem_shift} - {2'b00, divisor};
        fits      = ~trial[DIVISOR_BITS+1];
        rem_next  = fits ? trial[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
        quo_next  = {quo_reg[DIVIDEND_BITS-2:0], fits};
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### hw/rtl/dcbpd_datapath.sv
// ----------------------------------------------------------------------------
// dcbpd_datapath: histories, boxcar sums, dividers, peaks and result register
// Acts on commands from the controller and reports divider and output
// status back. Also holds the configuration registers.
// ----------------------------------------------------------------------------
module dcbpd_datapath #(
    parameter int WINDOW_MAX  = dcbpd_pkg::WINDOW_MAX_DEFAULT,
    parameter int SAMPLE_BITS = dcbpd_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dcbpd_pkg::dp_cmd_t                  cmd,
    output dcbpd_pkg::dp_status_t               status,
    input  logic                                cfg_write,
    input  logic [dcbpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dcbpd_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic [SAMPLE_BITS-1:0]              sample_a,
    input  logic [SAMPLE_BITS-1:0]              sample_b,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [dcbpd_pkg::INDEX_BITS-1:0]    delay,
    output logic                                delay_valid,
    output logic [SAMPLE_BITS-1:0]              peak_a,
    output logic [SAMPLE_BITS-1:0]              peak_b
);

    localparam int SB  = dcbpd_pkg::SUM_BITS;
    localparam int IB  = dcbpd_pkg::INDEX_BITS;
    localparam int AW  = $clog2(WINDOW_MAX);
    localparam int EW  = $clog2(WINDOW_MAX + 1);
    localparam logic [SB-1:0] MEAN_LIMIT = SB'((1 << SAMPLE_BITS) - 1);
    localparam logic [AW:0]   DEPTH      = (AW+1)'(WINDOW_MAX);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(WINDOW_MAX - 1);

    // Configuration
    logic [dcbpd_pkg::WLEN_BITS-1:0] wlen_reg;
    logic [dcbpd_pkg::SEP_BITS-1:0]  sep_reg;

    // Detector state
    logic [AW-1:0]          wp_reg;
    logic [WINDOW_MAX-1:0]  hist_valid_reg;
    logic [SB-1:0]          sum_a_reg;
    logic [SB-1:0]          sum_b_reg;
    logic [SAMPLE_BITS-1:0] best_a_reg;
    logic [SAMPLE_BITS-1:0] best_b_reg;
    logic [IB-1:0]          idx_a_reg;
    logic [IB-1:0]          idx_b_reg;
    logic [IB-1:0]          count_reg;

    // Captured item and leaving entries
    logic [SAMPLE_BITS-1:0] smp_a_reg;
    logic [SAMPLE_BITS-1:0] smp_b_reg;
    logic [SAMPLE_BITS-1:0] rd_a_reg;
    logic [SAMPLE_BITS-1:0] rd_b_reg;
    logic                   rd_valid_reg;

    // History memories
    logic [SAMPLE_BITS-1:0] hist_a_mem [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] hist_b_mem [WINDOW_MAX];

    // Result register
    logic                   out_valid_reg;
    logic [IB-1:0]          delay_reg;
    logic                   delay_valid_reg;
    logic [SAMPLE_BITS-1:0] peak_a_reg;
    logic [SAMPLE_BITS-1:0] peak_b_reg;

    logic [31:0]            eff32;
    logic [EW-1:0]          eff_wl;
    logic [AW:0]            back;
    logic [AW:0]            old_sum;
    logic [AW-1:0]          old_addr;
    logic [SAMPLE_BITS-1:0] leave_a;
    logic [SAMPLE_BITS-1:0] leave_b;
    logic [SB-1:0]          sum_a_next;
    logic [SB-1:0]          sum_b_next;
    logic [IB-1:0]          count_next;
    logic [SB-1:0]          quo_a;
    logic [SB-1:0]          quo_b;
    logic                   done_a;
    logic                   done_b;
    logic [SAMPLE_BITS-1:0] mean_a;
    logic [SAMPLE_BITS-1:0] mean_b;
    logic [IB-1:0]          diff;
    logic                   diff_ok;
    logic                   wlen_write;

    // Clamp the window length to 1..WINDOW_MAX
    always_comb
    begin
        priority if (wlen_reg == '0)
            eff32 = 32'd1;
        else if (32'(wlen_reg) > 32'(WINDOW_MAX))
            eff32 = 32'(WINDOW_MAX);
        else
            eff32 = 32'(wlen_reg);
        eff_wl = EW'(eff32);
    end

    // Address of the entry that leaves the window
    always_comb
    begin
        back     = DEPTH - (AW+1)'(eff_wl);
        old_sum  = {1'b0, wp_reg} + back;
        old_addr = (old_sum >= DEPTH) ? AW'(old_sum - DEPTH) : old_sum[AW-1:0];
    end

    // Next sums and saturating sample count
    always_comb
    begin
        leave_a    = rd_valid_reg ? rd_a_reg : '0;
        leave_b    = rd_valid_reg ? rd_b_reg : '0;
        sum_a_next = sum_a_reg + SB'(smp_a_reg) - SB'(leave_a);
        sum_b_next = sum_b_reg + SB'(smp_b_reg) - SB'(leave_b);
        count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    end

    // Means by window length, one quotient bit per cycle
    dcbpd_div #(
        .DIVIDEND_BITS (SB),
        .DIVISOR_BITS  (EW)
    ) u_div_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.accumulate),
        .dividend (sum_a_next),
        .divisor  (eff_wl),
        .quotient (quo_a),
        .done     (done_a)
    );

    dcbpd_div #(
        .DIVIDEND_BITS (SB),
        .DIVISOR_BITS  (EW)
    ) u_div_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.accumulate),
        .dividend (sum_b_next),
        .divisor  (eff_wl),
        .quotient (quo_b),
        .done     (done_b)
    );

    // Saturate means to the largest sample code
    always_comb
    begin
        mean_a = (quo_a > MEAN_LIMIT) ? '1 : quo_a[SAMPLE_BITS-1:0];
        mean_b = (quo_b > MEAN_LIMIT) ? '1 : quo_b[SAMPLE_BITS-1:0];
    end

    // Peak index difference and its check
    always_comb
    begin
        diff    = (idx_a_reg > idx_b_reg) ? idx_a_reg - idx_b_reg : idx_b_reg - idx_a_reg;
        diff_ok = (best_a_reg != '0) && (best_b_reg != '0) && (diff < sep_reg);
    end

    assign wlen_write = cfg_write && (cfg_index == dcbpd_pkg::CFG_WINDOW_LENGTH);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= dcbpd_pkg::WLEN_RESET;
            sep_reg  <= dcbpd_pkg::SEP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dcbpd_pkg::CFG_WINDOW_LENGTH:
                    wlen_reg <= cfg_data[dcbpd_pkg::WLEN_BITS-1:0];
                dcbpd_pkg::CFG_MAX_SEPARATION:
                    sep_reg <= cfg_data[dcbpd_pkg::SEP_BITS-1:0];
            endcase
        end
    end

    // Filter state: clear on window change or report, advance on accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            hist_valid_reg <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
        end
        else
        begin
            priority if (wlen_write || cmd.report)
            begin
                wp_reg         <= '0;
                hist_valid_reg <= '0;
                sum_a_reg      <= '0;
                sum_b_reg      <= '0;
            end
            else if (cmd.accumulate)
            begin
                wp_reg                 <= (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
                hist_valid_reg[wp_reg] <= 1'b1;
                sum_a_reg              <= sum_a_next;
                sum_b_reg              <= sum_b_next;
            end
        end
    end

    // Peaks, peak indices and sample count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_a_reg <= '0;
            best_b_reg <= '0;
            idx_a_reg  <= '0;
            idx_b_reg  <= '0;
            count_reg  <= '0;
        end
        else
        begin
            priority if (cmd.report)
            begin
                best_a_reg <= '0;
                best_b_reg <= '0;
                idx_a_reg  <= '0;
                idx_b_reg  <= '0;
                count_reg  <= '0;
            end
            else if (cmd.accumulate)
            begin
                count_reg <= count_next;
            end
            else if (cmd.update)
            begin
                if (mean_a > best_a_reg)
                begin
                    best_a_reg <= mean_a;
                    idx_a_reg  <= count_reg;
                end
                if (mean_b > best_b_reg)
                begin
                    best_b_reg <= mean_b;
                    idx_b_reg  <= count_reg;
                end
            end
        end
    end

    // Capture the item and read the leaving entries
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            smp_a_reg    <= sample_a;
            smp_b_reg    <= sample_b;
            rd_a_reg     <= hist_a_mem[old_addr];
            rd_b_reg     <= hist_b_mem[old_addr];
            rd_valid_reg <= hist_valid_reg[old_addr];
        end
    end

    // Write the new samples into the histories
    always_ff @(posedge clk)
    begin
        if (cmd.accumulate)
        begin
            hist_a_mem[wp_reg] <= smp_a_reg;
            hist_b_mem[wp_reg] <= smp_b_reg;
        end
    end

    // Result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.report)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            delay_reg       <= diff_ok ? diff : '0;
            delay_valid_reg <= diff_ok;
            peak_a_reg      <= best_a_reg;
            peak_b_reg      <= best_b_reg;
        end
    end

    assign status.div_done = done_a && done_b;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign delay       = delay_reg;
    assign delay_valid = delay_valid_reg;
    assign peak_a      = peak_a_reg;
    assign peak_b      = peak_b_reg;

endmodule

### hw/rtl/dcbpd_ctrl.sv
// ----------------------------------------------------------------------------
// dcbpd_ctrl: sequencer for sample and report items
// Accepts items, steps a sample through accumulate and divide, and issues
// report commands when the result register has room.
// ----------------------------------------------------------------------------
module dcbpd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  dcbpd_pkg::dp_status_t status,
    output dcbpd_pkg::dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Stall while busy, or a report while the result register is full
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE) ||
                   ((operation == dcbpd_pkg::OP_REPORT) && !status.out_free);
        accept   = in_valid && !in_stall;
    end

    // Commands
    always_comb
    begin
        cmd.capture    = accept && (operation == dcbpd_pkg::OP_SAMPLE);
        cmd.report     = accept && (operation == dcbpd_pkg::OP_REPORT);
        cmd.accumulate = (state_reg == ST_SUM);
        cmd.update     = (state_reg == ST_DIV) && status.div_done;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (cmd.capture)
                    state_next = ST_SUM;
            ST_SUM:
                state_next = ST_DIV;
            ST_DIV:
                if (status.div_done)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### hw/rtl/dual_channel_boxcar_peak_delay_unit.sv
// ----------------------------------------------------------------------------
// dual_channel_boxcar_peak_delay_unit: two-channel moving-average peak timer
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// A sample item (operation 0) keeps the input stalled until it is through:
// the entries leaving the window are read, the sums are updated and the
// histories written, the two restoring dividers form both window means one
// quotient bit per cycle over the 20-bit sums, and the means are compared
// with the peaks. Sample items give no result. A report item (operation 1)
// is taken whenever the result register is empty or being drained, and its
// result appears on the next cycle; it clears the peaks, peak indices, sums,
// sample count and history at once. Writing the window length clears the
// sums and history but keeps the peaks. History entries carry valid bits,
// so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module dual_channel_boxcar_peak_delay_unit #(
    parameter int WINDOW_MAX  = dcbpd_pkg::WINDOW_MAX_DEFAULT,
    parameter int SAMPLE_BITS = dcbpd_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [dcbpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dcbpd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 operation,
    input  logic [SAMPLE_BITS-1:0]               sample_a,
    input  logic [SAMPLE_BITS-1:0]               sample_b,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [dcbpd_pkg::INDEX_BITS-1:0]     delay,
    output logic                                 delay_valid,
    output logic [SAMPLE_BITS-1:0]               peak_a,
    output logic [SAMPLE_BITS-1:0]               peak_b
);

    dcbpd_pkg::dp_cmd_t    cmd;
    dcbpd_pkg::dp_status_t status;

    // Sequencer
    dcbpd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath
    dcbpd_datapath #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample_a    (sample_a),
        .sample_b    (sample_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .delay       (delay),
        .delay_valid (delay_valid),
        .peak_a      (peak_a),
        .peak_b      (peak_b)
    );

    // A report is never taken while an undrained result is held
    a_report_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && operation == dcbpd_pkg::OP_REPORT)
        |-> (!out_valid || !out_stall))
    else $error("report accepted while result register full");

    // A sample keeps the input stalled on the following cycle
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && operation == dcbpd_pkg::OP_SAMPLE) |=> in_stall)
    else $error("input accepted while a sample is still in work");

    // A new result only follows an accepted report
    a_result_from_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall &&
                                   operation == dcbpd_pkg::OP_REPORT))
    else $error("result appeared without a report item");

    // A valid delay needs both peaks nonzero
    a_delay_peaks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && delay_valid) |-> (peak_a != '0 && peak_b != '0))
    else $error("delay flagged valid with a zero peak");

endmodule

### bench/tb_dual_channel_boxcar_peak_delay_unit.sv
// ----------------------------------------------------------------------------
// tb_dual_channel_boxcar_peak_delay_unit: self-checking bench for the unit
// Drives a directed table of sample and report items, then phases of random
// items under changing window and separation settings and idle patterns.
// Every report is checked field by field against a cycle-free model of the
// boxcar filters, peak trackers and peak-time difference, or a table value.
// ----------------------------------------------------------------------------
module tb_dual_channel_boxcar_peak_delay_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles from a sample item's acceptance until the next item can be accepted
    localparam int SAMPLE_CYCLES   = 23;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int RING_DEPTH      = 256;

    // Operation and register codes
    localparam dcbpd_pkg::op_t        OP_SAMPLE          = dcbpd_pkg::OP_SAMPLE;
    localparam dcbpd_pkg::op_t        OP_REPORT          = dcbpd_pkg::OP_REPORT;
    localparam dcbpd_pkg::cfg_index_t CFG_WINDOW_LENGTH  = dcbpd_pkg::CFG_WINDOW_LENGTH;
    localparam dcbpd_pkg::cfg_index_t CFG_MAX_SEPARATION = dcbpd_pkg::CFG_MAX_SEPARATION;

    typedef struct packed {
        logic [19:0] delay;
        logic        delay_valid;
        logic [11:0] peak_a;
        logic [11:0] peak_b;
    } report_t;

    typedef enum logic [1:0] {
        STEP_PREDICT,
        STEP_FIXED,
        STEP_WRITE
    } step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        dcbpd_pkg::op_t        op;
        logic [11:0]           a;
        logic [11:0]           b;
        dcbpd_pkg::cfg_index_t sel;
        logic [19:0]           word;
        report_t               want;
    } step_t;

    typedef struct packed {
        logic [19:0] win_word;
        logic [19:0] sep_word;
        logic [6:0]  send_pct;
        logic [6:0]  stall_pct;
    } phase_t;

    localparam report_t NO_REP = '0;

    // Directed walk: extremes, both operations, window clamping, window
    // rewrite keeping the peaks, zero and unit separation limits
    localparam int SCRIPT_LEN = 32;
    localparam step_t SCRIPT [0:SCRIPT_LEN-1] = '{
        '{STEP_FIXED,   OP_REPORT, 12'h000, 12'h000, CFG_WINDOW_LENGTH, 20'h0,
          '{20'd0, 1'b0, 12'd0, 12'd0}},
        '{STEP_PREDICT, OP_SAMPLE, 12'hFFF, 12'hFFF, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_FIXED,   OP_REPORT, 12'h000, 12'h000, CFG_WINDOW_LENGTH, 20'h0,
          '{20'd0, 1'b1, 12'd20, 12'd20}},
        '{STEP_WRITE,   OP_SAMPLE, 12'h000, 12'h000, CFG_WINDOW_LENGTH, 20'd1, NO_REP},
        '{STEP_PREDICT, OP_SAMPLE, 12'h000, 12'h000, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_FIXED,   OP_REPORT, 12'h000, 12'h000, CFG_WINDOW_LENGTH, 20'h0,
          '{20'd0, 1'b0, 12'd0, 12'd0}},
        '{STEP_PREDICT, OP_SAMPLE, 12'hFFF, 12'h000, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_PREDICT, OP_SAMPLE, 12'h000, 12'hFFF, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_PREDICT, OP_SAMPLE, 12'hFFF, 12'hFFF, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_FIXED,   OP_REPORT, 12'h000, 12'h000, CFG_WINDOW_LENGTH, 20'h0,
          '{20'd1, 1'b1, 12'hFFF, 12'hFFF}},
        '{STEP_WRITE,   OP_SAMPLE, 12'h000, 12'h000, CFG_MAX_SEPARATION, 20'd0, NO_REP},
        '{STEP_PREDICT, OP_SAMPLE, 12'h001, 12'h002, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_FIXED,   OP_REPORT, 12'hFFF, 12'hFFF, CFG_WINDOW_LENGTH, 20'h0,
          '{20'd0, 1'b0, 12'd1, 12'd2}},
        '{STEP_WRITE,   OP_SAMPLE, 12'h000, 12'h000, CFG_MAX_SEPARATION, 20'hFFFFF, NO_REP},
        '{STEP_WRITE,   OP_SAMPLE, 12'h000, 12'h000, CFG_WINDOW_LENGTH, 20'd0, NO_REP},
        '{STEP_PREDICT, OP_SAMPLE, 12'hAAA, 12'h555, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_PREDICT, OP_SAMPLE, 12'h555, 12'hAAA, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_FIXED,   OP_REPORT, 12'h000, 12'h000, CFG_WINDOW_LENGTH, 20'h0,
          '{20'd1, 1'b1, 12'hAAA, 12'hAAA}},
        '{STEP_WRITE,   OP_SAMPLE, 12'h000, 12'h000, CFG_WINDOW_LENGTH, 20'h001FF, NO_REP},
        '{STEP_PREDICT, OP_SAMPLE, 12'hFFF, 12'hFFF, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_PREDICT, OP_SAMPLE, 12'hFFF, 12'h001, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_PREDICT, OP_REPORT, 12'h000, 12'h000, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_WRITE,   OP_SAMPLE, 12'h000, 12'h000, CFG_WINDOW_LENGTH, 20'd2, NO_REP},
        '{STEP_PREDICT, OP_SAMPLE, 12'hFFF, 12'hFFF, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_PREDICT, OP_SAMPLE, 12'hFFF, 12'hFFF, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_WRITE,   OP_SAMPLE, 12'h000, 12'h000, CFG_WINDOW_LENGTH, 20'd2, NO_REP},
        '{STEP_PREDICT, OP_SAMPLE, 12'h001, 12'h001, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_PREDICT, OP_REPORT, 12'h000, 12'h000, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_WRITE,   OP_SAMPLE, 12'h000, 12'h000, CFG_MAX_SEPARATION, 20'd1, NO_REP},
        '{STEP_PREDICT, OP_SAMPLE, 12'hFFF, 12'h000, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_PREDICT, OP_SAMPLE, 12'h000, 12'hFFF, CFG_WINDOW_LENGTH, 20'h0, NO_REP},
        '{STEP_PREDICT, OP_REPORT, 12'h000, 12'h000, CFG_WINDOW_LENGTH, 20'h0, NO_REP}
    };

    // Random phases: window word, separation limit, sender idle and
    // receiver stall percentages
    localparam int PHASE_COUNT = 8;
    localparam phase_t PHASES [0:PHASE_COUNT-1] = '{
        '{20'd4,      20'd50000,  7'd0,  7'd0},
        '{20'd1,      20'hFFFFF,  7'd50, 7'd0},
        '{20'd16,     20'd3,      7'd0,  7'd50},
        '{20'd256,    20'd1,      7'd22, 7'd22},
        '{20'd0,      20'd0,      7'd0,  7'd0},
        '{20'hFFE03,  20'd12,     7'd22, 7'd22},
        '{20'd300,    20'd50000,  7'd50, 7'd0},
        '{20'd201,    20'd50000,  7'd0,  7'd50}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    dcbpd_pkg::cfg_index_t cfg_index;
    logic [19:0]           cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    dcbpd_pkg::op_t        operation;
    logic [11:0]           sample_a;
    logic [11:0]           sample_b;
    logic                  out_valid;
    logic                  out_stall;
    logic [19:0]           delay;
    logic                  delay_valid;
    logic [11:0]           peak_a;
    logic [11:0]           peak_b;

    int unsigned send_pct;
    int unsigned stall_pct;
    int unsigned fault_count = 0;

    // Model of the detector
    logic [11:0] ring_a [0:RING_DEPTH-1];
    logic [11:0] ring_b [0:RING_DEPTH-1];
    logic [7:0]  ring_ptr;
    logic [19:0] boxsum_a;
    logic [19:0] boxsum_b;
    logic [11:0] top_a;
    logic [11:0] top_b;
    logic [19:0] top_at_a;
    logic [19:0] top_at_b;
    logic [19:0] pair_count;
    logic [8:0]  win_len;
    logic [19:0] sep_limit;

    report_t pending_reports [$];

    dual_channel_boxcar_peak_delay_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .sample_a    (sample_a),
        .sample_b    (sample_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .delay       (delay),
        .delay_valid (delay_valid),
        .peak_a      (peak_a),
        .peak_b      (peak_b)
    );

    always #5 clk = ~clk;

    // Clear the rings, sums and write pointer
    function automatic void clear_window();
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_a[i] = '0;
            ring_b[i] = '0;
        end
        ring_ptr = '0;
        boxsum_a = '0;
        boxsum_b = '0;
    endfunction

    // Clear everything but the registers
    function automatic void clear_detector();
        clear_window();
        top_a      = '0;
        top_b      = '0;
        top_at_a   = '0;
        top_at_b   = '0;
        pair_count = '0;
    endfunction

    function automatic logic [11:0] clamp_mean(input logic [19:0] sum, input int unsigned wl);
        int unsigned q;
        q = sum / wl;
        return (q > 32'hFFF) ? 12'hFFF : 12'(q);
    endfunction

    // Advance the detector by one item; a report yields a result
    function automatic void advance_detector(input dcbpd_pkg::op_t op, input logic [11:0] a,
                                             input logic [11:0] b, output bit gives,
                                             output report_t rep);
        int unsigned wl;
        logic [7:0]  leaving;
        logic [11:0] mean_a;
        logic [11:0] mean_b;
        logic [19:0] diff;
        gives = 1'b0;
        rep   = '0;
        if (op == OP_SAMPLE)
        begin
            wl = (win_len == 0) ? 1 : ((win_len > RING_DEPTH) ? RING_DEPTH : win_len);
            leaving = 8'((ring_ptr + RING_DEPTH - wl) % RING_DEPTH);
            if (pair_count != 20'hFFFFF)
                pair_count = pair_count + 20'd1;
            boxsum_a = boxsum_a + a - ring_a[leaving];
            boxsum_b = boxsum_b + b - ring_b[leaving];
            ring_a[ring_ptr] = a;
            ring_b[ring_ptr] = b;
            ring_ptr = ring_ptr + 8'd1;
            mean_a = clamp_mean(boxsum_a, wl);
            mean_b = clamp_mean(boxsum_b, wl);
            if (mean_a > top_a)
            begin
                top_a    = mean_a;
                top_at_a = pair_count;
            end
            if (mean_b > top_b)
            begin
                top_b    = mean_b;
                top_at_b = pair_count;
            end
        end
        else
        begin
            diff = (top_at_a > top_at_b) ? top_at_a - top_at_b : top_at_b - top_at_a;
            gives = 1'b1;
            rep.delay_valid = (top_a != 0) && (top_b != 0) && (diff < sep_limit);
            rep.delay  = rep.delay_valid ? diff : 20'd0;
            rep.peak_a = top_a;
            rep.peak_b = top_b;
            clear_detector();
        end
    endfunction

    function automatic logic [11:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 12'hFFF;
            1: return 12'h000;
            2, 3: return 12'($urandom_range(0, 63));
            default: return 12'($urandom);
        endcase
    endfunction

    // Offer one item, hold it until accepted, then predict its result
    task automatic send_item(input dcbpd_pkg::op_t op, input logic [11:0] a,
                             input logic [11:0] b, input bit fixed,
                             input report_t fixed_rep);
        bit      gives;
        report_t rep;
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        sample_a  <= a;
        sample_b  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_detector(op, a, b, gives, rep);
        if (gives)
            pending_reports.push_back(fixed ? fixed_rep : rep);
    endtask

    // Drop valid, drain all reports and let a sample item in flight finish
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (2 * SAMPLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input dcbpd_pkg::cfg_index_t sel, input logic [19:0] word);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= word;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (sel == CFG_WINDOW_LENGTH)
        begin
            win_len = word[8:0];
            clear_window();
        end
        else
            sep_limit = word;
    endtask

    // Check each accepted report and randomize the receiver stall
    always @(posedge clk)
    begin : report_check
        report_t got;
        report_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {delay, delay_valid, peak_a, peak_b};
                if (pending_reports.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: report with none pending: delay %0d valid %0d peaks %0d %0d",
                                 $realtime, got.delay, got.delay_valid, got.peak_a, got.peak_b);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (got.delay !== want.delay || got.delay_valid !== want.delay_valid ||
                        got.peak_a !== want.peak_a || got.peak_b !== want.peak_b)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("%0t: report mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     $realtime, want.delay, want.delay_valid, want.peak_a,
                                     want.peak_b, got.delay, got.delay_valid, got.peak_a,
                                     got.peak_b);
                    end
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Stimulus: reset, directed table, then random phases
    initial
    begin : stimulus
        int unsigned n;
        int unsigned p;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = CFG_WINDOW_LENGTH;
        cfg_data    = '0;
        in_valid    = 1'b0;
        operation   = OP_SAMPLE;
        sample_a    = '0;
        sample_b    = '0;
        send_pct    = 0;
        stall_pct   = 0;
        win_len     = dcbpd_pkg::WLEN_RESET;
        sep_limit   = dcbpd_pkg::SEP_RESET;
        clear_detector();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (n = 0; n < SCRIPT_LEN; n++)
        begin
            case (SCRIPT[n].kind)
                STEP_WRITE:
                begin
                    settle();
                    write_register(SCRIPT[n].sel, SCRIPT[n].word);
                end
                STEP_FIXED:
                    send_item(SCRIPT[n].op, SCRIPT[n].a, SCRIPT[n].b, 1'b1, SCRIPT[n].want);
                default:
                    send_item(SCRIPT[n].op, SCRIPT[n].a, SCRIPT[n].b, 1'b0, NO_REP);
            endcase
        end

        // Random phases, reports about one item in twelve
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            settle();
            write_register(CFG_WINDOW_LENGTH, PHASES[p].win_word);
            write_register(CFG_MAX_SEPARATION, PHASES[p].sep_word);
            send_pct  = PHASES[p].send_pct;
            stall_pct = PHASES[p].stall_pct;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_item(OP_REPORT, 12'($urandom), 12'($urandom), 1'b0, NO_REP);
                else
                    send_item(OP_SAMPLE, pick_sample(), pick_sample(), 1'b0, NO_REP);
            end
        end

        settle();
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hang guard
    initial
    begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### dual_channel_boxcar_peak_delay_unit.f
hw/rtl/dcbpd_pkg.sv
hw/rtl/dcbpd_div.sv
hw/rtl/dcbpd_datapath.sv
hw/rtl/dcbpd_ctrl.sv
hw/rtl/dual_channel_boxcar_peak_delay_unit.sv
bench/tb_dual_channel_boxcar_peak_delay_unit.sv
